/* hw/rtl/dtp_pkg.sv */
// shared types and constants of the decimal timestamp text parser
`default_nettype none
package dtp_pkg;

  localparam int CHAR_W     = 8;
  localparam int SECONDS_W  = 64;
  localparam int NANOS_W    = 30;
  localparam int OUT_DATA_W = 96;
  localparam int PAD_W      = OUT_DATA_W - SECONDS_W - NANOS_W;

  localparam logic [CHAR_W-1:0] COLON_CODE = 8'h3A;
  localparam logic [CHAR_W-1:0] DIGIT_ZERO = 8'h30;
  localparam logic [CHAR_W-1:0] DIGIT_NINE = 8'h39;
  localparam logic [33:0]       NANOS_LIMIT = 34'd1000000000;

  typedef struct packed {
    logic [CHAR_W-1:0] char_code;
    logic              is_last;
  } item_t;

  typedef struct packed {
    logic                 ok;
    logic [SECONDS_W-1:0] seconds_value;
    logic [NANOS_W-1:0]   nanos_value;
  } result_t;

endpackage
`default_nettype wire

/* hw/rtl/dtp_in_reg.sv */
// input register stage that holds one character item
`default_nettype none
module dtp_in_reg (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire dtp_pkg::item_t in_item,
  output logic               hold_valid,
  input  wire logic          hold_take,
  output dtp_pkg::item_t     hold_item
);
  import dtp_pkg::*;

  assign in_ready = !hold_valid || hold_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (in_ready) begin
      hold_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      hold_item <= in_item;
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/dtp_core.sv */
// parse state, digit accumulation and result register
`default_nettype none
module dtp_core (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           item_valid,
  input  wire dtp_pkg::item_t item,
  output logic                item_take,
  output logic                res_valid,
  input  wire logic           res_ready,
  output dtp_pkg::result_t    res
);
  import dtp_pkg::*;

  logic                 in_fraction, in_fraction_next;
  logic [SECONDS_W-1:0] sec_acc, sec_acc_next;
  logic                 sec_ovf, sec_ovf_next;
  logic [NANOS_W-1:0]   nano_acc, nano_acc_next;
  logic                 nano_big, nano_big_next;
  logic                 has_digit, has_digit_next;
  logic                 invalid, invalid_next;

  logic                 is_digit;
  logic [3:0]           digit;
  logic [SECONDS_W+3:0] sec_prod;
  logic [33:0]          nano_prod;
  logic                 res_free;
  logic                 ok;

  assign res_free  = !res_valid || res_ready;
  assign item_take = item_valid && (res_free || !item.is_last);

  assign is_digit = item.char_code inside {[DIGIT_ZERO:DIGIT_NINE]};
  assign digit    = item.char_code[3:0];

  // value times ten plus digit, widened to catch overflow
  assign sec_prod  = ({4'b0, sec_acc} << 3) + ({4'b0, sec_acc} << 1)
                   + {{SECONDS_W{1'b0}}, digit};
  assign nano_prod = ({4'b0, nano_acc} << 3) + ({4'b0, nano_acc} << 1)
                   + {30'b0, digit};

  always_comb begin
    in_fraction_next = in_fraction;
    sec_acc_next     = sec_acc;
    sec_ovf_next     = sec_ovf;
    nano_acc_next    = nano_acc;
    nano_big_next    = nano_big;
    has_digit_next   = has_digit;
    invalid_next     = invalid;
    if (is_digit) begin
      has_digit_next = 1'b1;
      if (!in_fraction) begin
        if (!sec_ovf) begin
          if (|sec_prod[SECONDS_W+3:SECONDS_W]) begin
            sec_ovf_next = 1'b1;
          end else begin
            sec_acc_next = sec_prod[SECONDS_W-1:0];
          end
        end
      end else if (!nano_big) begin
        if (nano_prod >= NANOS_LIMIT) begin
          nano_big_next = 1'b1;
        end else begin
          nano_acc_next = nano_prod[NANOS_W-1:0];
        end
      end
    end else if (item.char_code == COLON_CODE) begin
      if (in_fraction || !has_digit) begin
        invalid_next = 1'b1;
      end else begin
        in_fraction_next = 1'b1;
        has_digit_next   = 1'b0;
      end
    end else begin
      invalid_next = 1'b1;
    end
  end

  assign ok = !invalid_next && in_fraction_next && has_digit_next
            && !sec_ovf_next && !nano_big_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_fraction <= 1'b0;
      sec_acc     <= '0;
      sec_ovf     <= 1'b0;
      nano_acc    <= '0;
      nano_big    <= 1'b0;
      has_digit   <= 1'b0;
      invalid     <= 1'b0;
    end else if (item_take) begin
      if (item.is_last) begin
        in_fraction <= 1'b0;
        sec_acc     <= '0;
        sec_ovf     <= 1'b0;
        nano_acc    <= '0;
        nano_big    <= 1'b0;
        has_digit   <= 1'b0;
        invalid     <= 1'b0;
      end else begin
        in_fraction <= in_fraction_next;
        sec_acc     <= sec_acc_next;
        sec_ovf     <= sec_ovf_next;
        nano_acc    <= nano_acc_next;
        nano_big    <= nano_big_next;
        has_digit   <= has_digit_next;
        invalid     <= invalid_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (res_free) begin
      res_valid <= item_take && item.is_last;
    end
  end

  always_ff @(posedge clk) begin
    if (item_take && item.is_last) begin
      res.ok            <= ok;
      res.seconds_value <= ok ? sec_acc_next : '0;
      res.nanos_value   <= ok ? nano_acc_next : '0;
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/decimal_timestamp_text_parser.sv */
// top level of the decimal timestamp text parser
//
// input stream: one ascii character per item in s_axis_tdata, s_axis_tlast
// on the final character of a "seconds:nanoseconds" text
// output stream: one item per text, sent with the final character;
// m_axis_tuser is the ok flag, m_axis_tdata holds seconds in bits 63:0
// and nanoseconds in bits 93:64, both zero when ok is low
// throughput: one character per cycle while no final character waits for
// the result register, set by the single times-ten accumulate between the
// input register and the state registers; a result is registered at the
// edge that takes its final character, when the result register is free
// reset clears the parse state and both stages; no item is pending after
// when the receiver stalls the result register holds its item, characters
// that are not final keep flowing, and a final character waits in the
// input register until the result register is free
`default_nettype none
module decimal_timestamp_text_parser (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           s_axis_tvalid,
  output logic                                s_axis_tready,
  input  wire logic [dtp_pkg::CHAR_W-1:0]     s_axis_tdata,  // char_code
  input  wire logic                           s_axis_tlast,
  output logic                                m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  output logic [dtp_pkg::OUT_DATA_W-1:0]      m_axis_tdata,  // seconds_value, nanos_value
  output logic                                m_axis_tuser   // ok
);
  import dtp_pkg::*;

  item_t   in_item;
  item_t   hold_item;
  logic    hold_valid;
  logic    hold_take;
  result_t res;

  assign in_item.char_code = s_axis_tdata;
  assign in_item.is_last   = s_axis_tlast;

  dtp_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_item    (in_item),
    .hold_valid (hold_valid),
    .hold_take  (hold_take),
    .hold_item  (hold_item)
  );

  dtp_core u_core (
    .clk        (clk),
    .rst        (rst),
    .item_valid (hold_valid),
    .item       (hold_item),
    .item_take  (hold_take),
    .res_valid  (m_axis_tvalid),
    .res_ready  (m_axis_tready),
    .res        (res)
  );

  assign m_axis_tuser = res.ok;
  assign m_axis_tdata = {{PAD_W{1'b0}}, res.nanos_value, res.seconds_value};

endmodule
`default_nettype wire

/* hw/rtl/dtp_checker.sv */
// port level checks of the timestamp parser and their bind
`default_nettype none
module dtp_checker (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          s_axis_tvalid,
  input wire logic                          s_axis_tready,
  input wire logic [dtp_pkg::CHAR_W-1:0]    s_axis_tdata,
  input wire logic                          s_axis_tlast,
  input wire logic                          m_axis_tvalid,
  input wire logic                          m_axis_tready,
  input wire logic [dtp_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input wire logic                          m_axis_tuser
);
  import dtp_pkg::*;

  a_reset_empty: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result after reset");

  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == '0)
    else $error("rejected text with nonzero data");

  a_nanos_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser
      |-> {4'b0, m_axis_tdata[SECONDS_W+NANOS_W-1:SECONDS_W]} < NANOS_LIMIT)
    else $error("nanoseconds out of range");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready
      |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled result changed");

endmodule

bind decimal_timestamp_text_parser dtp_checker u_dtp_checker (.*);
`default_nettype wire
